[hw/rtl/small_risc_execute_unit_macros.svh]
// assertion macros for the small risc execute unit
`ifndef SMALL_RISC_EXECUTE_UNIT_MACROS_SVH
`define SMALL_RISC_EXECUTE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SRE_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define SRE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define SRE_ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg)
`define SRE_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif

`endif

[hw/rtl/sre_pkg.sv]
// types and constants of the small risc execute unit
package sre_pkg;

    localparam int WORD_W  = 32;
    localparam int OPC_W   = 5;
    localparam int FIELD_W = 3;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t WORD_STEP  = 32'd4;
    localparam word_t LOW_MASK   = 32'h0000_FFFF;
    localparam word_t HIGH_MASK  = 32'hFFFF_0000;
    localparam int    HALF_SHIFT = 16;
    localparam int    SIGN_POS   = 31;

    localparam logic OPER_EXEC      = 1'b0;
    localparam logic OPER_LOAD_DATA = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD      = 5'd0,
        OP_SUB      = 5'd1,
        OP_AND      = 5'd2,
        OP_OR       = 5'd3,
        OP_XOR      = 5'd4,
        OP_NOT      = 5'd5,
        OP_LOAD     = 5'd6,
        OP_STORE    = 5'd7,
        OP_JUMP     = 5'd8,
        OP_BRANCH   = 5'd9,
        OP_CMP      = 5'd10,
        OP_BEQ      = 5'd11,
        OP_BNE      = 5'd12,
        OP_BLT      = 5'd13,
        OP_BGT      = 5'd14,
        OP_LOADI    = 5'd15,
        OP_CALL     = 5'd16,
        OP_LOADI16  = 5'd17,
        OP_LOADI16H = 5'd18
    } opcode_t;

    typedef struct packed {
        logic               operation;
        logic [OPC_W-1:0]   opcode;
        logic [FIELD_W-1:0] dest_index;
        logic [FIELD_W-1:0] src1_index;
        logic [FIELD_W-1:0] src2_index;
        word_t              immediate;
        word_t              wide_immediate;
        word_t              load_data;
    } instr_t;

    typedef struct packed {
        word_t next_pc;
        logic  mem_read;
        logic  mem_write;
        word_t mem_address;
        word_t store_value;
        logic  invalid_op;
    } result_t;

    typedef struct packed {
        logic zero;
        logic negative;
        logic compare_seen;
    } flags_t;

    typedef struct packed {
        logic   reg_we;
        logic   reg_from_load;
        word_t  reg_wdata;
        logic   load_target_we;
        logic   flags_we;
        flags_t flags_value;
        word_t  pc_value;
    } upd_t;

endpackage

[hw/rtl/sre_if.sv]
// channel interfaces of the small risc execute unit
interface sre_in_if import sre_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [OPC_W-1:0]   opcode;
    logic [FIELD_W-1:0] dest_index;
    logic [FIELD_W-1:0] src1_index;
    logic [FIELD_W-1:0] src2_index;
    word_t              immediate;
    word_t              wide_immediate;
    word_t              load_data;

    modport source (
        output valid, operation, opcode, dest_index, src1_index, src2_index,
        output immediate, wide_immediate, load_data,
        input  ready
    );
    modport sink (
        input  valid, operation, opcode, dest_index, src1_index, src2_index,
        input  immediate, wide_immediate, load_data,
        output ready
    );
endinterface

interface sre_out_if import sre_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t next_pc;
    logic  mem_read;
    logic  mem_write;
    word_t mem_address;
    word_t store_value;
    logic  invalid_op;

    modport source (
        output valid, next_pc, mem_read, mem_write, mem_address, store_value, invalid_op,
        input  ready
    );
    modport sink (
        input  valid, next_pc, mem_read, mem_write, mem_address, store_value, invalid_op,
        output ready
    );
endinterface

interface sre_cfg_if import sre_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t start_address;

    modport source (
        output valid, start_address,
        input  ready
    );
    modport sink (
        input  valid, start_address,
        output ready
    );
endinterface

[hw/rtl/small_risc_execute_unit.sv]
// execute stage of a small risc: each accepted result is registered in the result buffer
// throughput one instruction or load-data transaction per cycle, set by the single
// register-file read, adder and compare pass ahead of the result buffer, while its skid
// register is empty; the two-entry buffer keeps accepting while one result waits
// asynchronous active-low reset clears registers, flags, pc and buffer; no clearing pass
`include "small_risc_execute_unit_macros.svh"

module small_risc_execute_unit import sre_pkg::*; #(
    parameter int REGISTER_COUNT = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    sre_cfg_if.sink   cfg,
    sre_in_if.sink    instr,
    sre_out_if.source result
);

    localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

    word_t            regs_reg [REGISTER_COUNT];
    word_t            pc_reg;
    word_t            pc_next;
    word_t            start_address_reg;
    flags_t           flags_reg;
    logic [IDX_W-1:0] load_target_reg;

    instr_t           item;
    result_t          res;
    upd_t             upd;
    logic             accept;
    logic             cfg_write;
    logic             can_push;
    logic [IDX_W-1:0] di_slot;
    logic [IDX_W-1:0] s1_slot;
    logic [IDX_W-1:0] s2_slot;
    logic [IDX_W-1:0] wr_slot;

    // index field folded onto the register count by a small lookup
    function automatic logic [IDX_W-1:0] slot_of(input logic [FIELD_W-1:0] idx);
        logic [IDX_W-1:0] slot;
        slot = '0;
        for (int k = 0; k < (1 << FIELD_W); k++)
            if (idx == FIELD_W'(k))
                slot = IDX_W'(k % REGISTER_COUNT);
        return slot;
    endfunction

    assign item.operation      = instr.operation;
    assign item.opcode         = instr.opcode;
    assign item.dest_index     = instr.dest_index;
    assign item.src1_index     = instr.src1_index;
    assign item.src2_index     = instr.src2_index;
    assign item.immediate      = instr.immediate;
    assign item.wide_immediate = instr.wide_immediate;
    assign item.load_data      = instr.load_data;

    assign cfg.ready   = 1'b1;
    assign cfg_write   = cfg.valid && cfg.ready;
    assign instr.ready = can_push;
    assign accept      = instr.valid && can_push;

    assign di_slot = slot_of(instr.dest_index);
    assign s1_slot = slot_of(instr.src1_index);
    assign s2_slot = slot_of(instr.src2_index);
    assign wr_slot = upd.reg_from_load ? load_target_reg : di_slot;

    sre_exec u_exec (
        .item    (item),
        .rd_val  (regs_reg[di_slot]),
        .rs1_val (regs_reg[s1_slot]),
        .rs2_val (regs_reg[s2_slot]),
        .pc      (pc_reg),
        .flags   (flags_reg),
        .res     (res),
        .upd     (upd)
    );

    sre_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .out_ch    (result)
    );

    always_comb
    begin
        pc_next = pc_reg;
        if (cfg_write)
            pc_next = cfg.start_address;
        else if (accept)
            pc_next = upd.pc_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
                regs_reg[i] <= '0;
            pc_reg            <= '0;
            start_address_reg <= '0;
            flags_reg         <= '0;
            load_target_reg   <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg_write)
                start_address_reg <= cfg.start_address;
            if (accept && upd.reg_we)
                regs_reg[wr_slot] <= upd.reg_wdata;
            if (accept && upd.flags_we)
                flags_reg <= upd.flags_value;
            if (accept && upd.load_target_we)
                load_target_reg <= di_slot;
        end
    end

    `SRE_ASSERT_IMPLIES(a_req_exclusive, clk, rst_n, result.valid,
        !(result.mem_read && result.mem_write), "read and write request in one result")
    `SRE_ASSERT_IMPLIES(a_invalid_quiet, clk, rst_n, result.valid && result.invalid_op,
        !result.mem_read && !result.mem_write, "memory request on invalid instruction")
    `SRE_ASSERT_IMPLIES(a_stall_has_result, clk, rst_n, !instr.ready, result.valid,
        "input stalled with no result pending")
    `SRE_ASSERT_NEXT(a_cfg_loads_pc, clk, rst_n, cfg_write, pc_reg == start_address_reg,
        "pc not loaded by start address write")

endmodule

[hw/rtl/sre_exec.sv]
// single-pass execute datapath: alu, compare, branch and memory request logic
module sre_exec import sre_pkg::*; (
    input  instr_t  item,
    input  word_t   rd_val,
    input  word_t   rs1_val,
    input  word_t   rs2_val,
    input  word_t   pc,
    input  flags_t  flags,
    output result_t res,
    output upd_t    upd
);

    word_t mem_addr;
    logic  bad_call;

    assign mem_addr = rs2_val + item.immediate;
    assign bad_call = (item.src1_index != '0) || (item.src2_index != '0)
                      || (item.immediate != '0);

    always_comb
    begin
        logic  take;
        logic  hold_pc;
        word_t offset;

        take     = 1'b0;
        hold_pc  = 1'b0;
        offset   = '0;
        res      = '0;
        upd      = '0;
        upd.flags_value = flags;

        if (item.operation == OPER_LOAD_DATA)
        begin
            upd.reg_we        = 1'b1;
            upd.reg_from_load = 1'b1;
            upd.reg_wdata     = item.load_data;
            hold_pc           = 1'b1;
        end
        else
        begin
            unique case (opcode_t'(item.opcode))
                OP_ADD:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = rs1_val + rs2_val;
                end
                OP_SUB:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = rs1_val - rs2_val;
                end
                OP_AND:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = rs1_val & rs2_val;
                end
                OP_OR:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = rs1_val | rs2_val;
                end
                OP_XOR:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = rs1_val ^ rs2_val;
                end
                OP_NOT:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = ~rs1_val;
                end
                OP_LOAD:
                begin
                    upd.load_target_we = 1'b1;
                    res.mem_read       = 1'b1;
                    res.mem_address    = mem_addr;
                end
                OP_STORE:
                begin
                    res.mem_write   = 1'b1;
                    res.mem_address = mem_addr;
                    res.store_value = rd_val;
                end
                OP_JUMP:
                begin
                    take = 1'b1;
                end
                OP_BRANCH:
                begin
                    take = (rs2_val == '0);
                end
                OP_CMP:
                begin
                    upd.flags_we                 = 1'b1;
                    upd.flags_value.zero         = (rs1_val == rs2_val);
                    upd.flags_value.negative     = ($signed(rs1_val) < $signed(rs2_val));
                    upd.flags_value.compare_seen = 1'b1;
                end
                OP_BEQ:
                begin
                    take = flags.compare_seen ? flags.zero : (rs2_val == '0);
                end
                OP_BNE:
                begin
                    take = flags.compare_seen ? !flags.zero : (rs2_val != '0);
                end
                OP_BLT:
                begin
                    take = flags.compare_seen ? flags.negative : rs2_val[SIGN_POS];
                end
                OP_BGT:
                begin
                    take = flags.compare_seen ? (!flags.negative && !flags.zero)
                                              : !rs2_val[SIGN_POS];
                end
                OP_LOADI:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = item.wide_immediate;
                end
                OP_CALL:
                begin
                    if (bad_call)
                    begin
                        res.invalid_op = 1'b1;
                        hold_pc        = 1'b1;
                    end
                end
                OP_LOADI16:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = (rd_val & HIGH_MASK) | (item.immediate & LOW_MASK);
                end
                OP_LOADI16H:
                begin
                    upd.reg_we    = 1'b1;
                    upd.reg_wdata = (rd_val & LOW_MASK)
                                    | ((item.immediate & LOW_MASK) << HALF_SHIFT);
                end
                default:
                begin
                    res.invalid_op = 1'b1;
                    hold_pc        = 1'b1;
                end
            endcase
        end

        offset = take ? item.immediate : '0;
        if (hold_pc)
            res.next_pc = pc;
        else if ((item.operation == OPER_EXEC) && (opcode_t'(item.opcode) == OP_CALL))
            res.next_pc = rd_val;
        else
            res.next_pc = pc + offset + WORD_STEP;
        upd.pc_value = res.next_pc;
    end

endmodule

[hw/rtl/sre_out_buf.sv]
// two-entry result buffer: output register plus skid register
module sre_out_buf import sre_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  result_t         push_data,
    output logic            can_push,
    sre_out_if.source       out_ch
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop      = out_valid_reg && out_ch.ready;
    assign can_push = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.next_pc     = out_data_reg.next_pc;
    assign out_ch.mem_read    = out_data_reg.mem_read;
    assign out_ch.mem_write   = out_data_reg.mem_write;
    assign out_ch.mem_address = out_data_reg.mem_address;
    assign out_ch.store_value = out_data_reg.store_value;
    assign out_ch.invalid_op  = out_data_reg.invalid_op;

endmodule
